@@ rtl/rie_pkg.sv @@
// Shared types, constants and opcodes of the RISC instruction executor.
package rie_pkg;

   localparam int DataDepthDefault = 4096;
   localparam int IoCountDefault   = 23;
   localparam int RegCountDefault  = 16;
   localparam int PcWidth          = 12;
   localparam int IoIdxWidth       = 5;
   localparam logic [4:0] IoIrqReturn = 5'd7;

   typedef enum logic [7:0] {
      OP_ADD = 8'd0, OP_SUB = 8'd1, OP_MUL = 8'd2, OP_AND = 8'd3, OP_OR = 8'd4,
      OP_XOR = 8'd5, OP_SLL = 8'd6, OP_SRA = 8'd7, OP_SRL = 8'd8, OP_BEQ = 8'd9,
      OP_BNE = 8'd10, OP_BLT = 8'd11, OP_BGT = 8'd12, OP_BLE = 8'd13, OP_BGE = 8'd14,
      OP_JAL = 8'd15, OP_LW = 8'd16, OP_SW = 8'd17, OP_RETI = 8'd18, OP_IN = 8'd19,
      OP_OUT = 8'd20, OP_HALT = 8'd21
   } opcode_type;

   typedef enum logic {
      REQ_EXEC = 1'b0,
      REQ_PRELOAD = 1'b1
   } req_op_type;

   typedef struct packed {
      logic        op;
      logic [19:0] instr_word;
      logic [19:0] imm_word;
      logic [11:0] load_addr;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [11:0] next_pc;
      logic        halted;
      logic        io_write_valid;
      logic [4:0]  io_index;
      logic [31:0] io_value;
      logic        interrupt_return;
   } rsp_type;

   // Decoded request handed from front to back
   typedef struct packed {
      logic        preload;
      logic [7:0]  opc;
      logic [3:0]  rd;
      logic [3:0]  rs;
      logic [3:0]  rt;
      logic        itype;
      logic [31:0] imm;
      logic [11:0] load_addr;
      logic [31:0] load_data;
   } dec_type;

endpackage

@@ rtl/risc_instruction_executor_core.sv @@
// Top level of the RISC instruction executor.
// Requests enter a two-entry decode queue; the back end takes one when idle,
// reads operands, then executes (held while the output register is full); lw
// adds a registered data memory read. One result per request, held in an output register.
module risc_instruction_executor_core #(
   parameter int DATA_DEPTH = rie_pkg::DataDepthDefault,
   parameter int IO_COUNT   = rie_pkg::IoCountDefault,
   parameter int REG_COUNT  = rie_pkg::RegCountDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  rie_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output rie_pkg::rsp_type rsp_item
);
   import rie_pkg::*;

   logic    dec_valid, dec_take;
   dec_type dec;

   // Front: accept and classify
   rie_front u_front (
      .clock, .reset, .push, .full, .req(req_item),
      .dec_valid, .dec_take, .dec
   );

   // Back: execute; register count fixed at sixteen
   rie_back #(.DATA_DEPTH(DATA_DEPTH), .IO_COUNT(IO_COUNT)) u_back (
      .clock, .reset, .dec_valid, .dec_take, .dec,
      .empty, .pop, .rsp(rsp_item)
   );

   a_regs: assert property (@(posedge clock) REG_COUNT == 16)
      else $error("register count must be sixteen");

endmodule

@@ rtl/rie_front.sv @@
// Front end: accepts requests, classifies them and queues decoded entries.
module rie_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  rie_pkg::req_type req,
   output logic             dec_valid,
   input  logic             dec_take,
   output rie_pkg::dec_type dec
);
   import rie_pkg::*;

   // Two-entry queue between front and back
   dec_type    q_ff [2];
   dec_type    q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic       acc;
   logic [7:0] opc;

   assign full = (cnt_ff == 2'd2);
   assign acc  = push && !full;
   assign opc  = req.instr_word[19:12];

   // Classification: immediate form and sign extension
   always_comb begin
      q_in.preload   = (req.op == REQ_PRELOAD);
      q_in.opc       = opc;
      q_in.rd        = req.instr_word[11:8];
      q_in.rs        = req.instr_word[7:4];
      q_in.rt        = req.instr_word[3:0];
      q_in.itype     = (opc != OP_HALT) && (opc != OP_RETI) &&
                       (q_in.rd == 4'd1 || q_in.rs == 4'd1 || q_in.rt == 4'd1);
      q_in.imm       = q_in.itype ? {{12{req.imm_word[19]}}, req.imm_word} : 32'd0;
      q_in.load_addr = req.load_addr;
      q_in.load_data = req.load_data;
   end

   always_comb begin
      cnt_in    = cnt_ff + {1'b0, acc} - {1'b0, dec_take};
      rd_ptr_in = rd_ptr_ff ^ dec_take;
      wr_ptr_in = wr_ptr_ff ^ acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

   assign dec_valid = (cnt_ff != 2'd0);
   assign dec       = q_ff[rd_ptr_ff];

   // Queue never overflows nor underflows
   a_no_over: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("front queue count out of range");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      dec_take |-> dec_valid) else $error("take from empty front queue");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (acc && !dec_take) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("front queue count did not advance");

endmodule

@@ rtl/rie_back.sv @@
// Back end: register file, data memory and I/O bank; executes decoded requests.
module rie_back #(
   parameter int DATA_DEPTH = rie_pkg::DataDepthDefault,
   parameter int IO_COUNT   = rie_pkg::IoCountDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             dec_valid,
   output logic             dec_take,
   input  rie_pkg::dec_type dec,
   output logic             empty,
   input  logic             pop,
   output rie_pkg::rsp_type rsp
);
   import rie_pkg::*;

   localparam int AW = $clog2(DATA_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_MEM  = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [11:0] pc_ff, pc_in;
   logic [31:0] rf_ff [16];
   logic [15:0] rf_vld_ff;
   logic [31:0] io_ff [IO_COUNT];
   logic [31:0] mem [DATA_DEPTH];
   logic [31:0] mem_q_ff;
   dec_type     cur_ff;
   logic [31:0] a_ff, b_ff, d_ff;

   // Output register
   rsp_type     out_ff, out_in;
   logic        full_ff, full_in;

   logic [31:0] a, b, dv, sum, wv, ldv;
   logic [7:0]  opc;
   logic [11:0] next, len_pc;
   logic        taken, we, mem_we, can_go;
   logic [AW-1:0] maddr;
   logic [4:0]  sh;

   // Register read with zero for 0, immediate for 1
   function automatic logic [31:0] rdreg(input logic [3:0] r, input logic [31:0] imm,
                                         input logic [31:0] v, input logic vld);
      logic [31:0] res;
      if (r == 4'd0) res = 32'd0;
      else if (r == 4'd1) res = imm;
      else res = vld ? v : 32'd0;
      return res;
   endfunction

   assign can_go   = !full_ff || pop;
   assign dec_take = (state_ff == ST_IDLE) && dec_valid;
   assign empty    = !full_ff;
   assign rsp      = out_ff;

   // Operands registered in the first cycle
   always_ff @(posedge clock) begin
      if (dec_take) begin
         cur_ff <= dec;
         a_ff   <= rdreg(dec.rs, dec.imm, rf_ff[dec.rs], rf_vld_ff[dec.rs]);
         b_ff   <= rdreg(dec.rt, dec.imm, rf_ff[dec.rt], rf_vld_ff[dec.rt]);
         d_ff   <= rdreg(dec.rd, dec.imm, rf_ff[dec.rd], rf_vld_ff[dec.rd]);
      end
   end

   assign opc   = cur_ff.opc;
   assign a     = a_ff;
   assign b     = b_ff;
   assign dv    = d_ff;
   assign sum   = a + b;
   assign maddr = sum[AW-1:0];
   assign sh    = b[4:0];
   assign len_pc = pc_ff + (cur_ff.itype ? 12'd2 : 12'd1);

   // Memory port: read in exec cycle, write on store or preload
   assign mem_we = (state_ff == ST_EXEC) && can_go &&
                   (cur_ff.preload || opc == OP_SW);
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cur_ff.preload ? AW'(cur_ff.load_addr) : maddr] <=
            cur_ff.preload ? cur_ff.load_data : dv;
      end
      mem_q_ff <= mem[maddr];
   end

   assign ldv = mem_q_ff[19] ? (mem_q_ff | 32'hFFF00000) : mem_q_ff;

   // Execute
   always_comb begin
      next  = len_pc;
      wv    = 32'd0;
      we    = 1'b0;
      taken = 1'b0;
      out_in = '0;
      unique case (opc)
         OP_ADD: begin wv = sum; we = 1'b1; end
         OP_SUB: begin wv = a - b; we = 1'b1; end
         OP_MUL: begin wv = a * b; we = 1'b1; end
         OP_AND: begin wv = a & b; we = 1'b1; end
         OP_OR:  begin wv = a | b; we = 1'b1; end
         OP_XOR: begin wv = a ^ b; we = 1'b1; end
         OP_SLL: begin wv = a << sh; we = 1'b1; end
         OP_SRA: begin wv = $unsigned($signed(a) >>> sh); we = 1'b1; end
         OP_SRL: begin wv = a >> sh; we = 1'b1; end
         OP_BEQ: taken = (a == b);
         OP_BNE: taken = (a != b);
         OP_BLT: taken = ($signed(a) < $signed(b));
         OP_BGT: taken = ($signed(a) > $signed(b));
         OP_BLE: taken = ($signed(a) <= $signed(b));
         OP_BGE: taken = ($signed(a) >= $signed(b));
         OP_JAL: begin
            if (cur_ff.rd > 4'd1) begin
               wv = {20'd0, len_pc};
               we = 1'b1;
               next = (cur_ff.rs == cur_ff.rd) ? len_pc : a[11:0];
            end
         end
         OP_IN: begin
            wv = (sum < 32'(IO_COUNT)) ? io_ff[sum[IoIdxWidth-1:0]] : 32'd0;
            we = 1'b1;
         end
         OP_OUT: begin
            if (sum < 32'(IO_COUNT)) begin
               out_in.io_write_valid = 1'b1;
               out_in.io_index = sum[IoIdxWidth-1:0];
               out_in.io_value = dv;
            end
         end
         OP_RETI: begin
            out_in.interrupt_return = 1'b1;
            next = io_ff[IoIrqReturn][11:0];
         end
         OP_HALT: begin
            out_in.halted = 1'b1;
            next = pc_ff;
         end
         default: ;
      endcase
      if (taken) next = dv[11:0];
      if (cur_ff.preload) begin
         next = pc_ff;
         out_in = '0;
         we = 1'b0;
      end
      out_in.next_pc = next;
   end

   // Control: idle -> exec -> (mem for loads) -> idle
   logic is_ld;
   assign is_ld = !cur_ff.preload && opc == OP_LW;
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      full_in  = full_ff && !pop;
      unique case (state_ff)
         ST_IDLE: if (dec_take) state_in = ST_EXEC;
         ST_EXEC: begin
            if (can_go) begin
               if (is_ld) state_in = ST_MEM;
               else begin
                  state_in = ST_IDLE;
                  pc_in    = next;
                  full_in  = 1'b1;
               end
            end
         end
         ST_MEM: begin
            state_in = ST_IDLE;
            pc_in    = next;
            full_in  = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic retire, rf_we;
   logic [31:0] rf_wd;
   assign retire = full_in && !(full_ff && !pop);
   assign rf_we  = ((state_ff == ST_EXEC && can_go && !is_ld && we && !cur_ff.preload) ||
                    (state_ff == ST_MEM && cur_ff.rd > 4'd1)) && cur_ff.rd > 4'd1;
   assign rf_wd  = (state_ff == ST_MEM) ? ldv : wv;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pc_ff     <= '0;
         full_ff   <= 1'b0;
         rf_vld_ff <= '0;
         for (int i = 0; i < IO_COUNT; i++) io_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         full_ff  <= full_in;
         if (rf_we) rf_vld_ff[cur_ff.rd] <= 1'b1;
         if (state_ff == ST_EXEC && can_go && out_in.io_write_valid)
            io_ff[out_in.io_index] <= out_in.io_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) rf_ff[cur_ff.rd] <= rf_wd;
      if (retire) out_ff <= out_in;
   end

   // Retire only when the output register is free
   a_ret_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !is_ld && !full_ff) |=> full_ff)
      else $error("result not retired");
   a_no_rf01: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> cur_ff.rd > 4'd1) else $error("write to fixed register");
   a_mem_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MEM |-> $past(state_ff) == ST_EXEC)
      else $error("memory stage without execute");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of the RISC instruction executor core.
`timescale 1ns / 100ps

module tb;
   import rie_pkg::*;

   localparam int MemDepth   = 4096;
   localparam int IoRegs     = 23;
   localparam int CycleLimit = 600000;
   localparam int HoldCycles = 400;

   // Predicts the architectural effect of each request and queues the result
   class exec_scoreboard;
      logic [11:0] pc;
      logic [31:0] regs[16];
      logic [31:0] io_regs[IoRegs];
      logic [31:0] mem[MemDepth];
      bit          written[MemDepth];
      rsp_type     expected_q[$];
      int          errors;

      function new();
         pc = '0;
         errors = 0;
         foreach (regs[i]) regs[i] = '0;
         foreach (io_regs[i]) io_regs[i] = '0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      // Immediate register value an instruction sees
      function logic [31:0] imm_value(req_type r);
         logic [7:0] opc;
         logic [3:0] rd, rs, rt;
         opc = r.instr_word[19:12];
         rd  = r.instr_word[11:8];
         rs  = r.instr_word[7:4];
         rt  = r.instr_word[3:0];
         if (opc != OP_HALT && opc != OP_RETI && (rd == 1 || rs == 1 || rt == 1))
            return {{12{r.imm_word[19]}}, r.imm_word};
         return '0;
      endfunction

      function logic [31:0] operand(logic [3:0] idx, logic [31:0] imm);
         if (idx == 0) return '0;
         if (idx == 1) return imm;
         return regs[idx];
      endfunction

      // Data memory address of a load or store
      function logic [11:0] mem_addr(req_type r);
         logic [31:0] imm;
         imm = imm_value(r);
         return 12'(operand(r.instr_word[7:4], imm) + operand(r.instr_word[3:0], imm));
      endfunction

      function void note_request(req_type r);
         rsp_type     res;
         logic [7:0]  opc;
         logic [3:0]  rd, rs, rt;
         logic [31:0] imm, a, b, sum, v;
         logic [11:0] nxt;
         bit          itype, taken;
         res = '0;
         if (r.op == REQ_PRELOAD) begin
            mem[r.load_addr] = r.load_data;
            written[r.load_addr] = 1'b1;
            res.next_pc = pc;
            expected_q.push_back(res);
            return;
         end
         opc = r.instr_word[19:12];
         rd  = r.instr_word[11:8];
         rs  = r.instr_word[7:4];
         rt  = r.instr_word[3:0];
         itype = opc != OP_HALT && opc != OP_RETI && (rd == 1 || rs == 1 || rt == 1);
         imm = imm_value(r);
         regs[0] = '0;
         regs[1] = imm;
         nxt = pc + (itype ? 12'd2 : 12'd1);
         a = regs[rs];
         b = regs[rt];
         sum = a + b;
         taken = 1'b0;
         case (opc)
            OP_ADD: if (rd > 1) regs[rd] = a + b;
            OP_SUB: if (rd > 1) regs[rd] = a - b;
            OP_MUL: if (rd > 1) regs[rd] = a * b;
            OP_AND: if (rd > 1) regs[rd] = a & b;
            OP_OR:  if (rd > 1) regs[rd] = a | b;
            OP_XOR: if (rd > 1) regs[rd] = a ^ b;
            OP_SLL: if (rd > 1) regs[rd] = a << b[4:0];
            OP_SRA: if (rd > 1) regs[rd] = $signed(a) >>> b[4:0];
            OP_SRL: if (rd > 1) regs[rd] = a >> b[4:0];
            OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_BLE, OP_BGE: begin
               case (opc)
                  OP_BEQ:  taken = a == b;
                  OP_BNE:  taken = a != b;
                  OP_BLT:  taken = $signed(a) < $signed(b);
                  OP_BGT:  taken = $signed(a) > $signed(b);
                  OP_BLE:  taken = $signed(a) <= $signed(b);
                  default: taken = $signed(a) >= $signed(b);
               endcase
               if (taken) nxt = regs[rd][11:0];
            end
            OP_JAL: if (rd > 1) begin
               regs[rd] = {20'd0, nxt};
               nxt = regs[rs][11:0];
            end
            OP_LW: if (rd > 1) begin
               v = mem[sum[11:0]];
               if (v[19]) v[31:20] = '1;
               regs[rd] = v;
            end
            OP_SW: begin
               mem[sum[11:0]] = regs[rd];
               written[sum[11:0]] = 1'b1;
            end
            OP_RETI: begin
               res.interrupt_return = 1'b1;
               nxt = io_regs[IoIrqReturn][11:0];
            end
            OP_IN: if (rd > 1) regs[rd] = (sum < IoRegs) ? io_regs[sum] : '0;
            OP_OUT: if (sum < IoRegs) begin
               io_regs[sum] = regs[rd];
               res.io_write_valid = 1'b1;
               res.io_index = sum[4:0];
               res.io_value = regs[rd];
            end
            OP_HALT: begin
               res.halted = 1'b1;
               nxt = pc;
            end
            default: ;
         endcase
         pc = nxt;
         res.next_pc = nxt;
         expected_q.push_back(res);
      endfunction

      function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, exp_v,
                  act_v);
      endfunction

      function void check_result(rsp_type act);
         rsp_type exp_r;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual 0x%0h", $time, act);
            return;
         end
         exp_r = expected_q.pop_front();
         if (act.next_pc !== exp_r.next_pc) report("next_pc", exp_r.next_pc, act.next_pc);
         if (act.halted !== exp_r.halted) report("halted", exp_r.halted, act.halted);
         if (act.io_write_valid !== exp_r.io_write_valid)
            report("io_write_valid", exp_r.io_write_valid, act.io_write_valid);
         if (act.io_index !== exp_r.io_index) report("io_index", exp_r.io_index, act.io_index);
         if (act.io_value !== exp_r.io_value) report("io_value", exp_r.io_value, act.io_value);
         if (act.interrupt_return !== exp_r.interrupt_return)
            report("interrupt_return", exp_r.interrupt_return, act.interrupt_return);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full, empty;
   req_type req_item = '0;
   rsp_type rsp_item;

   exec_scoreboard sb = new();
   int cycles = 0;
   int hold_left = 0;

   risc_instruction_executor_core dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: check on accept, stall on a drifting duty pattern
   int period = 1, duty = 0, phase = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) sb.check_result(rsp_item);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
         end else begin
            phase = phase + 1;
            if (phase >= period) begin
               phase = 0;
               if ($urandom_range(0, 7) == 0) begin
                  period = $urandom_range(1, 12);
                  duty = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, period);
               end
            end
            pop <= (phase >= duty);
         end
      end
   end

   // Offer one request and wait until it is taken
   task automatic send(req_type r);
      push <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic idle(int n);
      push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Issue a request; a load from a never written word gets a preload first
   task automatic issue(req_type r);
      req_type pre;
      logic [11:0] addr;
      if (r.op == REQ_EXEC && r.instr_word[19:12] == OP_LW) begin
         addr = sb.mem_addr(r);
         if (!sb.written[addr]) begin
            pre = '0;
            pre.op = REQ_PRELOAD;
            pre.load_addr = addr;
            pre.load_data = $urandom();
            send(pre);
         end
      end
      send(r);
   endtask

   function automatic req_type mk(logic [7:0] opc, logic [3:0] rd, logic [3:0] rs,
                                  logic [3:0] rt, logic [19:0] imm);
      req_type r;
      r = '0;
      r.op = REQ_EXEC;
      r.instr_word = {opc, rd, rs, rt};
      r.imm_word = imm;
      r.load_addr = 12'($urandom());
      r.load_data = $urandom();
      return r;
   endfunction

   function automatic req_type mk_preload(logic [11:0] addr, logic [31:0] data);
      req_type r;
      r = '0;
      r.op = REQ_PRELOAD;
      r.instr_word = 20'($urandom());
      r.imm_word = 20'($urandom());
      r.load_addr = addr;
      r.load_data = data;
      return r;
   endfunction

   function automatic logic [3:0] pick_reg();
      if ($urandom_range(0, 3) == 0) return 4'd1;
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic req_type random_request();
      logic [7:0]  opc;
      logic [19:0] imm;
      req_type     r;
      if ($urandom_range(0, 9) == 0)
         return mk_preload(12'($urandom()), $urandom());
      opc = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(22, 255))
                                        : 8'($urandom_range(0, 21));
      case ($urandom_range(0, 3))
         0: imm = 20'($urandom());
         1: imm = 20'($urandom_range(0, 40));
         2: imm = 20'hFFFFF - 20'($urandom_range(0, 40));
         default: imm = 20'($urandom_range(0, 4095));
      endcase
      r = mk(opc, pick_reg(), pick_reg(), pick_reg(), imm);
      // I/O and memory ops mostly use an immediate address
      if ((opc == OP_IN || opc == OP_OUT || opc == OP_LW || opc == OP_SW)
          && $urandom_range(0, 1) == 0) begin
         r.instr_word[7:0] = 8'h01;
         r.imm_word = (opc == OP_IN || opc == OP_OUT) ? 20'($urandom_range(0, 31))
                                                       : 20'($urandom_range(0, 4095));
      end
      // Halt would dominate little; keep register updates common
      if ($urandom_range(0, 4) == 0) r = mk(OP_ADD, 4'($urandom_range(2, 15)), 4'd0, 4'd1,
                                            20'($urandom()));
      return r;
   endfunction

   int n;
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests
      send(mk_preload(12'd0, 32'h0008_0000));
      send(mk_preload(12'hFFF, 32'hFFFF_FFFF));
      issue(mk(OP_ADD, 4'd2, 4'd0, 4'd1, 20'h7FFFF));
      issue(mk(OP_ADD, 4'd3, 4'd0, 4'd1, 20'h80000));
      issue(mk(OP_SUB, 4'd4, 4'd3, 4'd2, 20'd0));
      issue(mk(OP_MUL, 4'd5, 4'd2, 4'd3, 20'd0));
      issue(mk(OP_AND, 4'd6, 4'd2, 4'd3, 20'd0));
      issue(mk(OP_OR,  4'd7, 4'd2, 4'd3, 20'd0));
      issue(mk(OP_XOR, 4'd8, 4'd1, 4'd3, 20'hFFFFF));
      issue(mk(OP_SLL, 4'd9, 4'd2, 4'd1, 20'd45));
      issue(mk(OP_SRA, 4'd10, 4'd3, 4'd1, 20'd31));
      issue(mk(OP_SRL, 4'd11, 4'd3, 4'd1, 20'd4));
      issue(mk(OP_BEQ, 4'd1, 4'd2, 4'd2, 20'hFFABC));
      issue(mk(OP_BNE, 4'd1, 4'd2, 4'd3, 20'h00010));
      issue(mk(OP_BLT, 4'd1, 4'd3, 4'd2, 20'h00100));
      issue(mk(OP_BGT, 4'd2, 4'd3, 4'd2, 20'd0));
      issue(mk(OP_BLE, 4'd1, 4'd3, 4'd3, 20'h00200));
      issue(mk(OP_BGE, 4'd1, 4'd0, 4'd3, 20'h00300));
      issue(mk(OP_JAL, 4'd12, 4'd1, 4'd0, 20'h00400));
      issue(mk(OP_JAL, 4'd0, 4'd12, 4'd0, 20'd0));
      issue(mk(OP_LW, 4'd13, 4'd0, 4'd0, 20'd0));
      issue(mk(OP_LW, 4'd1, 4'd0, 4'd0, 20'd0));
      issue(mk(OP_SW, 4'd2, 4'd0, 4'd1, 20'hFFFFF));
      issue(mk(OP_OUT, 4'd12, 4'd0, 4'd1, 20'd7));
      issue(mk(OP_OUT, 4'd2, 4'd0, 4'd1, 20'd22));
      issue(mk(OP_OUT, 4'd2, 4'd0, 4'd1, 20'd23));
      issue(mk(OP_IN, 4'd14, 4'd0, 4'd1, 20'd7));
      issue(mk(OP_IN, 4'd15, 4'd1, 4'd0, 20'd30));
      issue(mk(OP_RETI, 4'd1, 4'd1, 4'd1, 20'hFFFFF));
      issue(mk(OP_HALT, 4'd0, 4'd0, 4'd0, 20'd0));
      issue(mk(8'hFF, 4'd1, 4'd0, 4'd0, 20'd0));
      idle(3);

      // Long receiver hold while the sender keeps offering
      hold_left = HoldCycles;
      for (int i = 0; i < 40; i++) issue(random_request());
      // Pause until everything is drained
      idle(1);
      while (sb.expected_q.size() != 0) @(posedge clock);

      // Random bursts with gaps
      n = 0;
      while (n < 1500) begin
         int burst;
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst; i++) begin
            issue(random_request());
            n++;
         end
         if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 8));
      end
      idle(1);

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
